// File: rtl/core/rgbycc_pkg.sv
package rgbycc_pkg;

  // Channel order inside one pixel: red, green, blue.
  localparam int unsigned NumPix  = 4;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 32;
  localparam int unsigned SumW    = 10;  // four 8-bit channel values
  localparam int unsigned YAccW   = 16;
  localparam int unsigned CAccW   = 18;

  localparam int unsigned ChanR = 0;
  localparam int unsigned ChanG = 1;
  localparam int unsigned ChanB = 2;

  localparam logic [YAccW-1:0] OffsetY  = YAccW'(128 + (16 << 8));
  // Chroma runs at quad scale for every mode: offset times four, shift by ten.
  localparam logic [CAccW-1:0] OffsetUv = CAccW'((128 + (128 << 8)) << 2);

  localparam int unsigned InDataW  = NumPix * PixW;
  localparam int unsigned OutDataW = 3 * NumPix * ChanW;

  typedef enum logic [1:0] {
    CM_444 = 2'd0,
    CM_422 = 2'd1,
    CM_420 = 2'd2
  } chroma_mode_e;

  typedef struct packed {
    logic [NumPix-1:0][NumChan-1:0][ChanW-1:0] pix;
    logic [NumPix-1:0][NumChan-1:0][SumW-1:0]  csum;
    logic [NumPix-1:0]                         cuse;
  } s1_t;

  typedef struct packed {
    logic [NumPix-1:0][YAccW-1:0] yacc;
    logic [NumPix-1:0][CAccW-1:0] cbacc;
    logic [NumPix-1:0][CAccW-1:0] cracc;
    logic [NumPix-1:0]            cuse;
  } s2_t;

endpackage

// File: rtl/core/rgb_to_ycbcr_subsampler_top.sv
// An accepted request passes through input unpack and chroma summing, then
// multiply-accumulate, then the output register.
// Throughput: one 2x2 quad per clock while the output is taken; each stage advances when the stage after
// it is empty or moving, so a held output still lets the earlier stages fill.
// Reset (rst_ni low, asynchronous) empties all stages and sets chroma mode 4:4:4.
module rgb_to_ycbcr_subsampler_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  input  logic [rgbycc_pkg::InDataW-1:0]        s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // cb_first .. cb_fourth, cr_first .. cr_fourth
  output logic [rgbycc_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  localparam int unsigned NP = rgbycc_pkg::NumPix;
  localparam int unsigned NC = rgbycc_pkg::NumChan;
  localparam int unsigned CW = rgbycc_pkg::ChanW;

  logic [1:0] mode_q;
  logic       v1_q, v2_q, v3_q;
  logic       en1, en2, en3;

  rgbycc_pkg::s1_t s1_d, s1_q;
  rgbycc_pkg::s2_t s2_d, s2_q;
  logic [rgbycc_pkg::OutDataW-1:0] out_d, out_q;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'(rgbycc_pkg::CM_444);
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Stage 1: split pixels and form the chroma source sums for each slot.
  // Every sum is brought to quad scale so one formula serves all modes.
  always_comb begin
    s1_d = '0;
    for (int p = 0; p < NP; p++) begin
      for (int c = 0; c < NC; c++) begin
        s1_d.pix[p][c] = s_axis_tdata_i[p*rgbycc_pkg::PixW + (NC-1-c)*CW +: CW];
      end
    end
    unique case (rgbycc_pkg::chroma_mode_e'(mode_q))
      rgbycc_pkg::CM_444: begin
        for (int p = 0; p < NP; p++) begin
          for (int c = 0; c < NC; c++) begin
            s1_d.csum[p][c] = {s1_d.pix[p][c], 2'b00};
          end
        end
        s1_d.cuse = 4'b1111;
      end
      rgbycc_pkg::CM_422: begin
        for (int h = 0; h < 2; h++) begin
          for (int c = 0; c < NC; c++) begin
            s1_d.csum[h][c] = {(9'(s1_d.pix[2*h][c]) + 9'(s1_d.pix[2*h+1][c])), 1'b0};
          end
        end
        s1_d.cuse = 4'b0011;
      end
      default: begin
        // 4:2:0, and the reserved code, average the whole quad.
        for (int c = 0; c < NC; c++) begin
          s1_d.csum[0][c] = 10'(s1_d.pix[0][c]) + 10'(s1_d.pix[1][c])
                          + 10'(s1_d.pix[2][c]) + 10'(s1_d.pix[3][c]);
        end
        s1_d.cuse = 4'b0001;
      end
    endcase
  end

  // Stage 2: constant-coefficient multiply-accumulate. Chroma results are
  // never negative, so modular arithmetic at the accumulator width is exact.
  always_comb begin
    s2_d      = '0;
    s2_d.cuse = s1_q.cuse;
    for (int p = 0; p < NP; p++) begin
      s2_d.yacc[p] = 16'd47  * 16'(s1_q.pix[p][rgbycc_pkg::ChanR])
                   + 16'd157 * 16'(s1_q.pix[p][rgbycc_pkg::ChanG])
                   + 16'd16  * 16'(s1_q.pix[p][rgbycc_pkg::ChanB])
                   + rgbycc_pkg::OffsetY;
      s2_d.cbacc[p] = 18'd112 * 18'(s1_q.csum[p][rgbycc_pkg::ChanB])
                    + rgbycc_pkg::OffsetUv
                    - 18'd26  * 18'(s1_q.csum[p][rgbycc_pkg::ChanR])
                    - 18'd86  * 18'(s1_q.csum[p][rgbycc_pkg::ChanG]);
      s2_d.cracc[p] = 18'd112 * 18'(s1_q.csum[p][rgbycc_pkg::ChanR])
                    + rgbycc_pkg::OffsetUv
                    - 18'd102 * 18'(s1_q.csum[p][rgbycc_pkg::ChanG])
                    - 18'd10  * 18'(s1_q.csum[p][rgbycc_pkg::ChanB]);
    end
  end

  // Stage 3: scale down and clear the chroma slots the mode leaves unused.
  always_comb begin
    out_d = '0;
    for (int p = 0; p < NP; p++) begin
      out_d[p*CW +: CW] = s2_q.yacc[p][rgbycc_pkg::YAccW-1 -: CW];
      if (s2_q.cuse[p]) begin
        out_d[(NP+p)*CW +: CW]   = s2_q.cbacc[p][rgbycc_pkg::CAccW-1 -: CW];
        out_d[(2*NP+p)*CW +: CW] = s2_q.cracc[p][rgbycc_pkg::CAccW-1 -: CW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (en3 && v2_q) begin
      out_q <= out_d;
    end
  end

  // An accepted request always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted request did not enter stage 1");

  // With the output stage empty the whole pipeline must be able to move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> s_axis_tready_o)
    else $error("input stalled while output stage is empty");

  // A stage holding data can only hand it on when the next stage moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(s2_q)))
    else $error("stage 2 data lost during a stall");

  // Chroma in a used slot is within the limited range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[5*CW-1 -: CW] >= 8'd16 &&
                         m_axis_tdata_o[5*CW-1 -: CW] <= 8'd240 &&
                         m_axis_tdata_o[9*CW-1 -: CW] >= 8'd16 &&
                         m_axis_tdata_o[9*CW-1 -: CW] <= 8'd240))
    else $error("first chroma value out of range");

endmodule

// File: tb/sv/rgb_to_ycbcr_subsampler_top_tb.sv
module rgb_to_ycbcr_subsampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbycc_pkg::*;

  localparam logic [1:0]  CmReserved  = 2'd3;
  localparam int unsigned LumaBias    = 32'd4224;
  localparam int unsigned ChromaBias  = 32'd32896;
  localparam int unsigned NumFields   = 12;
  localparam int unsigned CbBase      = 4;
  localparam int unsigned CrBase      = 8;
  localparam int unsigned ReportLimit = 40;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [1:0]          cfg_wdata_i     = 2'd0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // luma_top_left .. luma_bottom_right, cb_first .. cb_fourth, cr_first .. cr_fourth
  logic [OutDataW-1:0] m_axis_tdata_o;

  logic [1:0]          cur_mode      = CM_444;
  int unsigned         tx_idle_pct   = 0;
  int unsigned         rx_idle_pct   = 0;
  int unsigned         mismatch_count = 0;
  logic [OutDataW-1:0] pending_ycbcr [$];

  string FieldName [NumFields] = '{
    "luma_top_left", "luma_top_right", "luma_bottom_left", "luma_bottom_right",
    "cb_first", "cb_second", "cb_third", "cb_fourth",
    "cr_first", "cr_second", "cr_third", "cr_fourth"
  };

  rgb_to_ycbcr_subsampler_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // Channel values may be sums over one, two or four pixels; bias and shift scale
  // with the count. The true results are never negative, so wrapping is harmless.
  function automatic logic [7:0] cb_level(input int unsigned r, input int unsigned g,
                                          input int unsigned b, input int unsigned bias,
                                          input int unsigned sh);
    int unsigned acc;
    acc = 32'd112 * b + bias - 32'd26 * r - 32'd86 * g;
    return 8'(acc >> sh);
  endfunction

  function automatic logic [7:0] cr_level(input int unsigned r, input int unsigned g,
                                          input int unsigned b, input int unsigned bias,
                                          input int unsigned sh);
    int unsigned acc;
    acc = 32'd112 * r + bias - 32'd102 * g - 32'd10 * b;
    return 8'(acc >> sh);
  endfunction

  function automatic logic [OutDataW-1:0] predict_ycbcr(input logic [InDataW-1:0] quad,
                                                        input logic [1:0] mode);
    int unsigned         r [NumPix];
    int unsigned         g [NumPix];
    int unsigned         b [NumPix];
    int unsigned         sr;
    int unsigned         sg;
    int unsigned         sb;
    logic [OutDataW-1:0] res;
    res = '0;
    for (int p = 0; p < NumPix; p++) begin
      r[p] = 32'(quad[p*PixW+16 +: 8]);
      g[p] = 32'(quad[p*PixW+8 +: 8]);
      b[p] = 32'(quad[p*PixW +: 8]);
      res[p*8 +: 8] = 8'((32'd47 * r[p] + 32'd157 * g[p] + 32'd16 * b[p] + LumaBias) >> 8);
    end
    if (mode == CM_444) begin
      for (int p = 0; p < NumPix; p++) begin
        res[(CbBase+p)*8 +: 8] = cb_level(r[p], g[p], b[p], ChromaBias, 8);
        res[(CrBase+p)*8 +: 8] = cr_level(r[p], g[p], b[p], ChromaBias, 8);
      end
    end else if (mode == CM_422) begin
      for (int k = 0; k < 2; k++) begin
        sr = r[2*k] + r[2*k+1];
        sg = g[2*k] + g[2*k+1];
        sb = b[2*k] + b[2*k+1];
        res[(CbBase+k)*8 +: 8] = cb_level(sr, sg, sb, ChromaBias << 1, 9);
        res[(CrBase+k)*8 +: 8] = cr_level(sr, sg, sb, ChromaBias << 1, 9);
      end
    end else begin
      // Bit 1 selects quad averaging, so the reserved code behaves as 4:2:0.
      sr = r[0] + r[1] + r[2] + r[3];
      sg = g[0] + g[1] + g[2] + g[3];
      sb = b[0] + b[1] + b[2] + b[3];
      res[CbBase*8 +: 8] = cb_level(sr, sg, sb, ChromaBias << 2, 10);
      res[CrBase*8 +: 8] = cr_level(sr, sg, sb, ChromaBias << 2, 10);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < ReportLimit) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    logic [OutDataW-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_ycbcr.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", m_axis_tdata_o));
      end else begin
        want = pending_ycbcr.pop_front();
        for (int f = 0; f < NumFields; f++) begin
          if (m_axis_tdata_o[f*8 +: 8] !== want[f*8 +: 8]) begin
            report_mismatch($sformatf("%s got %h want %h", FieldName[f],
                                      m_axis_tdata_o[f*8 +: 8], want[f*8 +: 8]));
          end
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_quad(input logic [InDataW-1:0] quad);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= quad;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_ycbcr.push_back(predict_ycbcr(quad, cur_mode));
  endtask

  // Leaves the block empty: every result in, plus the pipeline depth to spare.
  task automatic drain_pipeline();
    s_axis_tvalid_i <= 1'b0;
    while (pending_ycbcr.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_chroma_mode(input logic [1:0] mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = mode;
  endtask

  function automatic logic [PixW-1:0] random_pixel();
    logic [PixW-1:0] px;
    px = $urandom;
    // Now and then pin channels to black or full scale.
    if ($urandom_range(3) == 0) begin
      for (int c = 0; c < NumChan; c++) begin
        if ($urandom_range(1) == 1) begin
          px[c*8 +: 8] = $urandom_range(1) == 1 ? 8'hff : 8'h00;
        end
      end
    end
    return px;
  endfunction

  task automatic test_mode_extremes(input logic [1:0] mode);
    write_chroma_mode(mode);
    send_quad('0);
    send_quad('1);
    send_quad({32'h00ffffff, 32'h000000ff, 32'h0000ff00, 32'h00ff0000});
    send_quad({32'hff000000, 32'h00ffffff, 32'h00ff00ff, 32'hff00ffff});
    drain_pipeline();
  endtask

  task automatic test_alpha_ignored();
    write_chroma_mode(CM_444);
    send_quad({4{32'h00a05a3c}});
    send_quad({4{32'hffa05a3c}});
    drain_pipeline();
  endtask

  task automatic test_random_stream(input int unsigned count, input int unsigned tx_pct,
                                    input int unsigned rx_pct, input int unsigned first);
    logic [InDataW-1:0] quad;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < 4; k++) begin
      write_chroma_mode(2'((first + k) % 4));
      for (int n = 0; n < count / 4; n++) begin
        for (int p = 0; p < NumPix; p++) begin
          quad[p*PixW +: PixW] = random_pixel();
        end
        send_quad(quad);
      end
      drain_pipeline();
    end
  endtask

  initial begin
    tx_idle_pct = 17;
    rx_idle_pct = 56;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mode_extremes(CM_444);
    test_mode_extremes(CM_422);
    test_mode_extremes(CM_420);
    test_mode_extremes(CmReserved);
    test_alpha_ignored();
    test_random_stream(520, 17, 56, 0);
    test_random_stream(520, 56, 17, 1);
    test_random_stream(520, 0, 0, 2);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
